// File: hdl/lbr_pkg.sv
// lbr_pkg: shared constants, types and command/status structs for the
// bounded random generator core. No dependencies.
`default_nettype none

package lbr_pkg;

  // field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned DrawW  = 15;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned InTdW  = 64;
  localparam int unsigned OutTdW = 48;

  // generator constants
  localparam logic [DataW-1:0] LcgMul    = 32'd214013;
  localparam logic [DataW-1:0] LcgAdd    = 32'd2531011;
  localparam int unsigned      DrawShift = 16;

  // last remainder step index
  localparam logic [IdxW-1:0] DivLast = IdxW'(DrawW - 1);

  // controller to datapath commands
  typedef struct packed {
    logic            load_in;
    logic            setup;
    logic            step_gen;
    logic            div_step;
    logic [IdxW-1:0] div_idx;
    logic            load_out;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic span_zero;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/lbr_datapath.sv
// lbr_datapath: generator state, bound ordering, span, restoring remainder
// and result clamp. Depends on lbr_pkg.
`default_nettype none

module lbr_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_wr_en_i,
  input  wire logic [lbr_pkg::DataW-1:0]   cfg_wr_data_i,
  input  wire logic [lbr_pkg::DataW-1:0]   bound_a_i,
  input  wire logic [lbr_pkg::DataW-1:0]   bound_b_i,
  input  wire lbr_pkg::ctrl_cmd_t          cmd_i,
  output lbr_pkg::dp_status_t              status_o,
  output logic      [lbr_pkg::DataW-1:0]   value_o,
  output logic      [lbr_pkg::DrawW-1:0]   raw_draw_o,
  output logic                             drew_o
);

  logic [lbr_pkg::DataW-1:0] gen_q, gen_d;
  logic [lbr_pkg::DataW-1:0] prod_q;
  logic [lbr_pkg::DataW-1:0] lo_q, hi_q;
  logic [lbr_pkg::DrawW-1:0] mag_q;
  logic                      big_q;
  logic                      zero_q;
  logic [lbr_pkg::DrawW-1:0] draw_q;
  logic [lbr_pkg::DrawW-1:0] rem_q, rem_d;
  logic [lbr_pkg::DataW-1:0] value_q, value_d;
  logic [lbr_pkg::DrawW-1:0] raw_q, raw_d;
  logic                      drew_q, drew_d;

  logic                      b_lt_a;
  logic [lbr_pkg::DataW-1:0] span;
  logic [lbr_pkg::DataW-1:0] mag_full;
  logic [lbr_pkg::DrawW:0]   partial;
  logic [lbr_pkg::DrawW:0]   partial_sub;
  logic [lbr_pkg::DrawW-1:0] rem_sel;
  logic [lbr_pkg::DataW-1:0] sum;

  // bound ordering and span
  assign b_lt_a   = $signed(bound_b_i) < $signed(bound_a_i);
  assign span     = hi_q - lo_q + lbr_pkg::DataW'(1);
  assign mag_full = span[lbr_pkg::DataW-1] ? (lbr_pkg::DataW'(0) - span) : span;
  assign status_o.span_zero = (span == '0);

  // generator next state
  assign gen_d = prod_q + lbr_pkg::LcgAdd;

  // one restoring remainder step, draw bits msb first
  assign partial     = {rem_q, draw_q[cmd_i.div_idx]};
  assign partial_sub = partial - {1'b0, mag_q};
  always_comb begin
    if (partial >= {1'b0, mag_q}) begin
      rem_d = partial_sub[lbr_pkg::DrawW-1:0];
    end else begin
      rem_d = partial[lbr_pkg::DrawW-1:0];
    end
  end

  // offset by low bound and clamp to the bounds
  assign rem_sel = big_q ? draw_q : rem_q;
  assign sum     = lo_q + {{(lbr_pkg::DataW - lbr_pkg::DrawW){1'b0}}, rem_sel};
  always_comb begin
    if (zero_q) begin
      value_d = '0;
      raw_d   = '0;
      drew_d  = 1'b0;
    end else begin
      raw_d  = draw_q;
      drew_d = 1'b1;
      if ($signed(sum) < $signed(lo_q)) begin
        value_d = lo_q;
      end else if ($signed(hi_q) < $signed(sum)) begin
        value_d = hi_q;
      end else begin
        value_d = sum;
      end
    end
  end

  // generator state: seed reload or step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cfg_wr_en_i) begin
      gen_q <= cfg_wr_data_i;
    end else if (cmd_i.step_gen) begin
      gen_q <= gen_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      lo_q   <= b_lt_a ? bound_b_i : bound_a_i;
      hi_q   <= b_lt_a ? bound_a_i : bound_b_i;
      prod_q <= gen_q * lbr_pkg::LcgMul;
    end
    if (cmd_i.setup) begin
      mag_q  <= mag_full[lbr_pkg::DrawW-1:0];
      big_q  <= |mag_full[lbr_pkg::DataW-1:lbr_pkg::DrawW];
      zero_q <= status_o.span_zero;
    end
    if (cmd_i.step_gen) begin
      draw_q <= gen_d[lbr_pkg::DrawShift +: lbr_pkg::DrawW];
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
    end
    if (cmd_i.load_out) begin
      value_q <= value_d;
      raw_q   <= raw_d;
      drew_q  <= drew_d;
    end
  end

  assign value_o    = value_q;
  assign raw_draw_o = raw_q;
  assign drew_o     = drew_q;

  // generator state moves only on a seed write or a step
  gen_moves_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(gen_q) |-> $past(cfg_wr_en_i) || $past(cmd_i.step_gen))
    else $error("generator state changed without step or seed write");

  // remainder stays below the divisor while dividing a span that fits the draw width
  rem_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step && !big_q |-> rem_q < mag_q)
    else $error("partial remainder not below divisor");

  // a no-draw result carries zero value and draw
  zero_out_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && zero_q |=> value_q == '0 && raw_q == '0)
    else $error("zero span result not zero");

endmodule

`default_nettype wire

// File: hdl/lbr_ctrl.sv
// lbr_ctrl: sequencing state machine and output valid for the bounded
// random core. Depends on lbr_pkg.
`default_nettype none

module lbr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire lbr_pkg::dp_status_t  status_i,
  output lbr_pkg::ctrl_cmd_t        cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StGen   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [lbr_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = status_i.span_zero ? StDone : StGen;
      end
      StGen: begin
        cmd_o.step_gen = 1'b1;
        cnt_d          = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_idx  = lbr_pkg::DivLast - cnt_q;
        if (cnt_q == lbr_pkg::DivLast) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + lbr_pkg::IdxW'(1);
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // step counter never runs past the last draw bit
  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> cnt_q <= lbr_pkg::DivLast)
    else $error("remainder step counter out of range");

  // output register is loaded only when its slot is free
  no_overwrite_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before transfer");

  // an accepted transfer starts setup on the next cycle
  accept_setup_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StSetup)
    else $error("accepted transfer did not start setup");

endmodule

`default_nettype wire

// File: hdl/lcg_bounded_random_core.sv
// lcg_bounded_random_core: top level of the bounded random generator.
// Instantiates lbr_ctrl and lbr_datapath; depends on lbr_pkg.
//
// channel   dir  signals                         contents
// s_axis    in   tvalid tready tdata[63:0]       bound_a, bound_b
// m_axis    out  tvalid tready tdata[47:0] tuser value, raw_draw / drew
// cfg       in   cfg_wr_en cfg_wr_data[31:0]     seed_value
//
// an item with a nonzero span passes through setup, a generator step, the
// one-bit-per-cycle restoring remainder unit and the output load
// a full-range item (span wraps to zero) skips the draw
// the result sits in an output register, so the next item is accepted and
// worked on while the previous result waits on m_axis_tready_i
// reset clears the generator state to zero; a seed write reloads it

`default_nettype none

module lcg_bounded_random_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // seed register write
  input  wire logic                         cfg_wr_en_i,
  input  wire logic [lbr_pkg::DataW-1:0]    cfg_wr_data_i,
  // request stream
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [lbr_pkg::InTdW-1:0]    s_axis_tdata_i,  // bound_a, bound_b
  // result stream
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic      [lbr_pkg::OutTdW-1:0]   m_axis_tdata_o,  // value, raw_draw, zero pad
  output logic                              m_axis_tuser_o   // drew
);

  lbr_pkg::ctrl_cmd_t        cmd;
  lbr_pkg::dp_status_t       status;
  logic [lbr_pkg::DataW-1:0] value;
  logic [lbr_pkg::DrawW-1:0] raw_draw;
  logic                      drew;

  // sequencer
  lbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and result registers
  lbr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .bound_a_i     (s_axis_tdata_i[lbr_pkg::DataW-1:0]),
    .bound_b_i     (s_axis_tdata_i[2*lbr_pkg::DataW-1:lbr_pkg::DataW]),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_o       (value),
    .raw_draw_o    (raw_draw),
    .drew_o        (drew)
  );

  // pack result transfer
  assign m_axis_tdata_o = {{(lbr_pkg::OutTdW - lbr_pkg::DataW - lbr_pkg::DrawW){1'b0}},
                           raw_draw, value};
  assign m_axis_tuser_o = drew;

endmodule

`default_nettype wire

// File: tb/tb_lcg_bounded_random_core.sv
// tb_lcg_bounded_random_core: self-checking testbench for the bounded random core.
// Runs a directed table and then random requests under several seeds, with a
// built-in predictor. Depends on lbr_pkg and lcg_bounded_random_core.

module tb_lcg_bounded_random_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DirCount      = 22;
  localparam int unsigned PhaseItems    = 200;
  localparam int unsigned TailItems     = 100;
  localparam int unsigned HoldAt        = 300;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned DrainCycles   = 25;
  localparam int unsigned EndCycles     = 40;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned MaxPrinted    = 40;

  // generator constants, kept apart from the package
  localparam logic [31:0] LcgMultiplier = 32'd214013;
  localparam logic [31:0] LcgIncrement  = 32'd2531011;
  localparam logic [31:0] SignMin       = 32'h8000_0000;
  localparam logic [31:0] SignMax       = 32'h7fff_ffff;

  // one result: value, raw draw, advance flag
  typedef struct packed {
    logic [31:0] value;
    logic [14:0] raw_draw;
    logic        drew;
  } rand_result_t;

  typedef struct {
    logic [31:0]  bound_a;
    logic [31:0]  bound_b;
    bit           typed;
    rand_result_t want;
  } stim_row_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_wr_en_i     = 1'b0;
  logic [lbr_pkg::DataW-1:0]    cfg_wr_data_i   = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [lbr_pkg::InTdW-1:0]    s_axis_tdata_i  = '0;  // bound_a, bound_b
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [lbr_pkg::OutTdW-1:0]   m_axis_tdata_o;        // value, raw_draw, zero pad
  logic                         m_axis_tuser_o;        // drew

  logic [31:0]  lcg_state = '0;
  rand_result_t expected_values[$];
  rand_result_t oldest;
  int unsigned  error_cnt     = 0;
  int unsigned  sent_cnt      = 0;
  int unsigned  full_cnt      = 0;
  int unsigned  checked_cnt   = 0;
  int unsigned  seed_cnt      = 0;
  int unsigned  stall_cycles  = 0;
  bit           hold_active   = 1'b0;
  bit           hold_done     = 1'b0;
  bit           tail_phase    = 1'b0;

  // directed requests, state starts from reset (zero)
  stim_row_t directed_rows [DirCount] = '{
    '{32'd7,            32'd7,            1'b1, '{32'd7, 15'd38,   1'b1}},
    '{SignMin,          SignMax,          1'b1, '{32'd0, 15'd0,    1'b0}},
    '{SignMax,          SignMin,          1'b1, '{32'd0, 15'd0,    1'b0}},
    '{32'd0,            32'd0,            1'b1, '{32'd0, 15'd7719, 1'b1}},
    '{SignMin,          SignMin,          1'b0, '{32'd0, 15'd0,    1'b0}},
    '{SignMax,          SignMax,          1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'd0,            32'hffff_ffff,    1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'hffff_ffff,    32'd0,            1'b0, '{32'd0, 15'd0,    1'b0}},
    '{SignMin,          32'd0,            1'b0, '{32'd0, 15'd0,    1'b0}},
    '{SignMax,          32'hffff_ffff,    1'b0, '{32'd0, 15'd0,    1'b0}},
    '{SignMin,          SignMax - 32'd1,  1'b0, '{32'd0, 15'd0,    1'b0}},
    '{SignMax,          SignMin + 32'd1,  1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'd0,            32'd100,          1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'd100,          32'hffff_ff9c,    1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'd0,            32'd32767,        1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'd32766,        32'd0,            1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'd0,            32'd65535,        1'b0, '{32'd0, 15'd0,    1'b0}},
    '{SignMax - 32'd10, SignMax,          1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'hffff_fffb,    SignMax,          1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'h5555_5555,    32'haaaa_aaaa,    1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'haaaa_aaaa,    32'h5555_5555,    1'b0, '{32'd0, 15'd0,    1'b0}},
    '{32'd1,            32'd2,            1'b0, '{32'd0, 15'd0,    1'b0}}
  };

  lcg_bounded_random_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // order the bounds, step the generator unless the span wraps to zero
  function automatic rand_result_t next_bounded_value(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        span;
    logic [31:0]        mag;
    logic [31:0]        val;
    logic [14:0]        draw;
    rand_result_t       res;
    lo   = (b < a) ? b : a;
    hi   = (b < a) ? a : b;
    span = hi - lo + 32'd1;
    res  = '0;
    if (span != 32'd0) begin
      lcg_state = lcg_state * LcgMultiplier + LcgIncrement;
      draw = lcg_state[30:16];
      // negative span as signed: remainder uses its magnitude
      mag = span[31] ? (32'd0 - span) : span;
      val = ({17'd0, draw} % mag) + lo;
      if ($signed(val) < lo) begin
        val = lo;
      end else if ($signed(val) > hi) begin
        val = hi;
      end
      res.value    = val;
      res.raw_draw = draw;
      res.drew     = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_cnt < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
    end
    error_cnt++;
  endtask

  // drive one request and record its expectation at the accepting edge
  task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                              input bit typed, input rand_result_t want);
    rand_result_t predicted;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = next_bounded_value(a, b);
    expected_values.push_back(typed ? want : predicted);
    sent_cnt++;
    if (!predicted.drew) full_cnt++;
    if (!tail_phase && !hold_active && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // random request mix: narrow ranges, wide, equal, full range, extremes
  task automatic random_request();
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  w;
    int unsigned  kind;
    kind = $urandom_range(0, 99);
    a    = $urandom;
    b    = $urandom;
    if (kind < 40) begin
      w = $urandom_range(0, 32'd1 << $urandom_range(0, 17));
      b = a + w;
    end else if (kind < 60) begin
      b = $urandom;
    end else if (kind < 70) begin
      b = a;
    end else if (kind < 75) begin
      a = SignMin;
      b = SignMax;
    end else if (kind < 85) begin
      a = SignMin + $urandom_range(0, 40000);
      b = ($urandom_range(0, 1) != 0) ? SignMax - $urandom_range(0, 40000)
                                      : SignMin + $urandom_range(0, 40000);
    end else begin
      w = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
      b = a + w;
    end
    if ($urandom_range(0, 1) != 0) begin
      w = a;
      a = b;
      b = w;
    end
    send_request(a, b, 1'b0, '0);
  endtask

  // reload the seed once everything in flight has come out
  task automatic load_seed(input logic [31:0] seed);
    s_axis_tvalid_i <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= seed;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    lcg_state = seed;
    seed_cnt++;
  endtask

  // stimulus
  initial begin
    logic [31:0] seeds [4];
    seeds[0] = 32'hffff_ffff;
    seeds[1] = 32'h0000_0000;
    seeds[2] = $urandom;
    seeds[3] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DirCount; i++) begin
      send_request(directed_rows[i].bound_a, directed_rows[i].bound_b,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    for (int p = 0; p < 4; p++) begin
      load_seed(seeds[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 3 && n == PhaseItems - TailItems) tail_phase = 1'b1;
        random_request();
      end
    end
    s_axis_tvalid_i <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (EndCycles) @(posedge clk_i);
    $display("Covered %0d requests (%0d full range), %0d results checked, %0d seed loads",
             sent_cnt, full_cnt, checked_cnt, seed_cnt);
    $display("Included a %0d-cycle result hold-off and an idle-free closing stretch",
             HoldCycles);
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random hold-offs, calm stretches, one long hold
  initial begin
    int unsigned calm_left;
    calm_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_cnt >= HoldAt) begin
        hold_active = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (tail_phase || calm_left != 0) begin
        m_axis_tready_i <= 1'b1;
        if (calm_left != 0) calm_left--;
      end else if ($urandom_range(0, 39) == 0) begin
        calm_left = $urandom_range(30, 120);
        m_axis_tready_i <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o[31:0], '0);
      end else begin
        oldest = expected_values.pop_front();
        checked_cnt++;
        if (m_axis_tdata_o[31:0] !== oldest.value) begin
          report_mismatch("value", m_axis_tdata_o[31:0], oldest.value);
        end
        if (m_axis_tdata_o[46:32] !== oldest.raw_draw) begin
          report_mismatch("raw_draw", {17'd0, m_axis_tdata_o[46:32]}, {17'd0, oldest.raw_draw});
        end
        if (m_axis_tuser_o !== oldest.drew) begin
          report_mismatch("drew", {31'd0, m_axis_tuser_o}, {31'd0, oldest.drew});
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          cfg_wr_en_i) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, stall_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
